FILE: hdl/bilinear_image_resize_top_macros.svh
// Assertion macros for the bilinear scaler RTL.
// Used by bilinear_image_resize_top.sv; expects clk and rst_n in scope.
`ifndef BILINEAR_IMAGE_RESIZE_TOP_MACROS_SVH
`define BILINEAR_IMAGE_RESIZE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BIR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BIR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bir_pkg.sv
// Shared types and constants of the bilinear scaler.
// No dependencies; imported by every RTL module of the block.
package bir_pkg;

  localparam int FRAC_BITS      = 8;
  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int MAX_DST_SIZE   = 1024;

  localparam int COORD_W = 10;
  localparam int PIX_W   = 8;
  localparam int SW_W    = 9;
  localparam int DW_W    = 11;
  localparam int SX_W    = $clog2(MAX_SRC_WIDTH);
  localparam int SY_W    = $clog2(MAX_SRC_HEIGHT);
  localparam int POS_W   = ((SX_W > SY_W) ? SX_W : SY_W) + FRAC_BITS;
  localparam int NUM_W   = COORD_W + SW_W + FRAC_BITS;
  localparam int DIV_STAGES = POS_W;
  localparam int BANK_AW = (SX_W - 1) + (SY_W - 1);
  localparam int WGT_W   = FRAC_BITS + 1;
  localparam int Q_W     = WGT_W + PIX_W;
  localparam int V_W     = WGT_W + Q_W;

  localparam logic [WGT_W-1:0] ONE_FX = WGT_W'(1) << FRAC_BITS;

  typedef enum logic {OP_LOAD, OP_SAMPLE} op_t;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT
  } reg_idx_t;

  typedef struct packed {
    logic               valid;
    op_t                op;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   pix;
  } item_t;

  typedef struct packed {
    logic               we;
    logic [SX_W-1:0]    col;
    logic [SY_W-1:0]    row;
    logic [PIX_W-1:0]   data;
  } wr_req_t;

  typedef struct packed {
    logic [SX_W-1:0] x1;
    logic [SX_W-1:0] x2;
    logic [SY_W-1:0] y1;
    logic [SY_W-1:0] y2;
  } rd_req_t;

endpackage

FILE: hdl/bir_div.sv
// Pipelined restoring divider: one quotient bit per stage, overflow flagged up front.
// Depends on bir_pkg.
module bir_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bir_pkg::NUM_W-1:0]   num,
  input  logic [bir_pkg::DW_W-1:0]    den,
  output logic [bir_pkg::POS_W-1:0]   quo,
  output logic                        ovf
);
  import bir_pkg::*;

  logic [DW_W-1:0]  rem_r   [0:DIV_STAGES];
  logic [POS_W-1:0] numlo_r [0:DIV_STAGES];
  logic [POS_W-1:0] q_r     [0:DIV_STAGES];
  logic             ovf_r   [0:DIV_STAGES];

  // Quotient does not fit in POS_W bits: position is out of range anyway.
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0]   <= (num[NUM_W-1:POS_W] >= den);
      rem_r[0]   <= (num[NUM_W-1:POS_W] >= den) ? '0 : num[NUM_W-1:POS_W];
      numlo_r[0] <= num[POS_W-1:0];
      q_r[0]     <= '0;
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    logic [DW_W:0]   rem_sh;
    logic            take;
    logic [DW_W-1:0] rem_nxt;

    always_comb begin
      rem_sh  = {rem_r[k-1], numlo_r[k-1][POS_W-1]};
      take    = (rem_sh >= {1'b0, den});
      rem_nxt = take ? DW_W'(rem_sh - {1'b0, den}) : rem_sh[DW_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]   <= rem_nxt;
        numlo_r[k] <= {numlo_r[k-1][POS_W-2:0], 1'b0};
        q_r[k]     <= {q_r[k-1][POS_W-2:0], take};
        ovf_r[k]   <= ovf_r[k-1];
      end
    end
  end

  assign quo = q_r[DIV_STAGES];
  assign ovf = ovf_r[DIV_STAGES];

endmodule

FILE: hdl/bir_store.sv
// Source image store split into four banks by column/row parity. Depends on bir_pkg.
// One write and four neighbor reads per cycle while en is high; read data registered.
module bir_store (
  input  logic                       clk,
  input  logic                       en,
  input  bir_pkg::wr_req_t           wr,
  input  bir_pkg::rd_req_t           rd,
  output logic [bir_pkg::PIX_W-1:0]  p1,
  output logic [bir_pkg::PIX_W-1:0]  p2,
  output logic [bir_pkg::PIX_W-1:0]  p3,
  output logic [bir_pkg::PIX_W-1:0]  p4
);
  import bir_pkg::*;

  logic [PIX_W-1:0] bank_q [0:3];
  logic             x1p_r, x2p_r, y1p_r, y2p_r;

  // Bank index is {row parity, column parity}.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0] mem [0:(1<<BANK_AW)-1];
    logic [SX_W-1:0]  xs;
    logic [SY_W-1:0]  ys;
    logic [BANK_AW-1:0] raddr;
    logic [BANK_AW-1:0] waddr;
    logic             wsel;

    always_comb begin
      // Pick whichever neighbor column/row has this bank's parity.
      xs    = (rd.x1[0] == b[0]) ? rd.x1 : rd.x2;
      ys    = (rd.y1[0] == b[1]) ? rd.y1 : rd.y2;
      raddr = {ys[SY_W-1:1], xs[SX_W-1:1]};
      waddr = {wr.row[SY_W-1:1], wr.col[SX_W-1:1]};
      wsel  = wr.we && (wr.col[0] == b[0]) && (wr.row[0] == b[1]);
    end

    always_ff @(posedge clk) begin
      if (en && wsel) begin
        mem[waddr] <= wr.data;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        bank_q[b] <= mem[raddr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1p_r <= rd.x1[0];
      x2p_r <= rd.x2[0];
      y1p_r <= rd.y1[0];
      y2p_r <= rd.y2[0];
    end
  end

  assign p1 = bank_q[{y1p_r, x1p_r}];
  assign p2 = bank_q[{y1p_r, x2p_r}];
  assign p3 = bank_q[{y2p_r, x1p_r}];
  assign p4 = bank_q[{y2p_r, x2p_r}];

endmodule

FILE: hdl/bilinear_image_resize_top.sv
// Throughput: one item per cycle while the result sink does not stall; the divider
// pipeline (one quotient bit per stage) sets the depth, the four-bank image store
// supplies all neighbors in one read.
// Reset (rst_n low, synchronous): sizes go to 256x256 -> 512x512, pipeline valids clear;
// the image store is not cleared and is undefined until loaded.
`include "bilinear_image_resize_top_macros.svh"

module bilinear_image_resize_top (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [9:0] col, [19:10] row, [27:20] pixel_in, rest zero
  input  logic        in_tuser,   // [0] operation
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] pixel_out, [17:8] out_col, [27:18] out_row
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bir_pkg::*;

  typedef struct packed {
    item_t              itm;
    logic               inr;
    logic [SX_W-1:0]    x1;
    logic [SX_W-1:0]    x2;
    logic [SY_W-1:0]    y1;
    logic [SY_W-1:0]    y2;
    logic [FRAC_BITS-1:0] a;
    logic [FRAC_BITS-1:0] b;
  } pos_t;

  typedef struct packed {
    item_t                itm;
    logic                 inr;
    logic [FRAC_BITS-1:0] a;
    logic [FRAC_BITS-1:0] b;
  } rd_stage_t;

  typedef struct packed {
    item_t                itm;
    logic                 inr;
    logic [FRAC_BITS-1:0] b;
    logic [Q_W-1:0]       q1;
    logic [Q_W-1:0]       q2;
  } blend_t;

  // Configuration registers
  logic [SW_W-1:0] sw_r, sh_r;
  logic [DW_W-1:0] dw_r, dh_r;
  logic [SW_W-1:0] sw_eff, sh_eff;
  logic [DW_W-1:0] dw_eff, dh_eff;
  logic            cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r <= SW_W'(256);
      sh_r <= SW_W'(256);
      dw_r <= DW_W'(512);
      dh_r <= DW_W'(512);
    end else if (cfg_wr) begin
      case (reg_idx_t'(cfg_paddr[3:2]))
        REG_SRC_WIDTH:  sw_r <= cfg_pwdata[SW_W-1:0];
        REG_SRC_HEIGHT: sh_r <= cfg_pwdata[SW_W-1:0];
        REG_DST_WIDTH:  dw_r <= cfg_pwdata[DW_W-1:0];
        REG_DST_HEIGHT: dh_r <= cfg_pwdata[DW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(cfg_paddr[3:2]))
      REG_SRC_WIDTH:  cfg_prdata = 32'(sw_r);
      REG_SRC_HEIGHT: cfg_prdata = 32'(sh_r);
      REG_DST_WIDTH:  cfg_prdata = 32'(dw_r);
      REG_DST_HEIGHT: cfg_prdata = 32'(dh_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Zero acts as one, oversize saturates.
  always_comb begin
    sw_eff = (sw_r == '0) ? SW_W'(1) : (sw_r > SW_W'(MAX_SRC_WIDTH))  ? SW_W'(MAX_SRC_WIDTH)  : sw_r;
    sh_eff = (sh_r == '0) ? SW_W'(1) : (sh_r > SW_W'(MAX_SRC_HEIGHT)) ? SW_W'(MAX_SRC_HEIGHT) : sh_r;
    dw_eff = (dw_r == '0) ? DW_W'(1) : (dw_r > DW_W'(MAX_DST_SIZE))   ? DW_W'(MAX_DST_SIZE)   : dw_r;
    dh_eff = (dh_r == '0) ? DW_W'(1) : (dh_r > DW_W'(MAX_DST_SIZE))   ? DW_W'(MAX_DST_SIZE)   : dh_r;
  end

  // Pipeline advance: hold everything while a result waits on a stalled sink.
  logic en;
  logic out_valid_r;
  logic [PIX_W-1:0]   out_pixel_r;
  logic [COORD_W-1:0] out_col_r, out_row_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Stage A: register item and form the division numerators
  item_t            a_r;
  logic [NUM_W-1:0] numx_r, numy_r;
  item_t            in_item;

  always_comb begin
    in_item.valid = in_tvalid;
    in_item.op    = op_t'(in_tuser);
    in_item.col   = in_tdata[COORD_W-1:0];
    in_item.row   = in_tdata[2*COORD_W-1:COORD_W];
    in_item.pix   = in_tdata[2*COORD_W+PIX_W-1:2*COORD_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r.valid <= 1'b0;
    end else if (en) begin
      a_r.valid <= in_item.valid;
    end
    if (en) begin
      a_r.op  <= in_item.op;
      a_r.col <= in_item.col;
      a_r.row <= in_item.row;
      a_r.pix <= in_item.pix;
      numx_r  <= NUM_W'(NUM_W'(in_item.col) * NUM_W'(sw_eff)) << FRAC_BITS;
      numy_r  <= NUM_W'(NUM_W'(in_item.row) * NUM_W'(sh_eff)) << FRAC_BITS;
    end
  end

  // Divider stages, with the item riding alongside
  logic [POS_W-1:0] qx, qy;
  logic             ovfx, ovfy;
  item_t            dl_r [0:DIV_STAGES];

  bir_div u_div_x (.clk(clk), .en(en), .num(numx_r), .den(dw_eff), .quo(qx), .ovf(ovfx));
  bir_div u_div_y (.clk(clk), .en(en), .num(numy_r), .den(dh_eff), .quo(qy), .ovf(ovfy));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_STAGES; i++) begin
        dl_r[i].valid <= 1'b0;
      end
    end else if (en) begin
      dl_r[0].valid <= a_r.valid;
      for (int i = 1; i <= DIV_STAGES; i++) begin
        dl_r[i].valid <= dl_r[i-1].valid;
      end
    end
    if (en) begin
      dl_r[0].op  <= a_r.op;
      dl_r[0].col <= a_r.col;
      dl_r[0].row <= a_r.row;
      dl_r[0].pix <= a_r.pix;
      for (int i = 1; i <= DIV_STAGES; i++) begin
        dl_r[i].op  <= dl_r[i-1].op;
        dl_r[i].col <= dl_r[i-1].col;
        dl_r[i].row <= dl_r[i-1].row;
        dl_r[i].pix <= dl_r[i-1].pix;
      end
    end
  end

  // Stage P: integer/fraction split, range check, far neighbor clamp
  pos_t p_r, p_nxt;
  logic [SX_W-1:0] x1;
  logic [SY_W-1:0] y1;

  always_comb begin
    x1          = qx[FRAC_BITS+SX_W-1:FRAC_BITS];
    y1          = qy[FRAC_BITS+SY_W-1:FRAC_BITS];
    p_nxt.itm   = dl_r[DIV_STAGES];
    p_nxt.inr   = !ovfx && !ovfy
                  && (SW_W'(qx[POS_W-1:FRAC_BITS]) < sw_eff)
                  && (SW_W'(qy[POS_W-1:FRAC_BITS]) < sh_eff);
    p_nxt.x1    = x1;
    p_nxt.y1    = y1;
    p_nxt.x2    = (SW_W'(x1) == SW_W'(sw_eff - SW_W'(1))) ? x1 : x1 + SX_W'(1);
    p_nxt.y2    = (SW_W'(y1) == SW_W'(sh_eff - SW_W'(1))) ? y1 : y1 + SY_W'(1);
    p_nxt.a     = qx[FRAC_BITS-1:0];
    p_nxt.b     = qy[FRAC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r.itm.valid <= 1'b0;
    end else if (en) begin
      p_r.itm.valid <= p_nxt.itm.valid;
    end
    if (en) begin
      p_r.itm.op  <= p_nxt.itm.op;
      p_r.itm.col <= p_nxt.itm.col;
      p_r.itm.row <= p_nxt.itm.row;
      p_r.itm.pix <= p_nxt.itm.pix;
      p_r.inr     <= p_nxt.inr;
      p_r.x1      <= p_nxt.x1;
      p_r.x2      <= p_nxt.x2;
      p_r.y1      <= p_nxt.y1;
      p_r.y2      <= p_nxt.y2;
      p_r.a       <= p_nxt.a;
      p_r.b       <= p_nxt.b;
    end
  end

  // Stage M: loads write and samples read the store at the same stage, keeping order
  wr_req_t          wr;
  rd_req_t          rd;
  logic [PIX_W-1:0] p1, p2, p3, p4;
  rd_stage_t        m_r;

  always_comb begin
    wr.we   = p_r.itm.valid && (p_r.itm.op == OP_LOAD)
              && (p_r.itm.col < COORD_W'(MAX_SRC_WIDTH))
              && (p_r.itm.row < COORD_W'(MAX_SRC_HEIGHT));
    wr.col  = p_r.itm.col[SX_W-1:0];
    wr.row  = p_r.itm.row[SY_W-1:0];
    wr.data = p_r.itm.pix;
    rd.x1   = p_r.x1;
    rd.x2   = p_r.x2;
    rd.y1   = p_r.y1;
    rd.y2   = p_r.y2;
  end

  bir_store u_store (
    .clk(clk), .en(en), .wr(wr), .rd(rd),
    .p1(p1), .p2(p2), .p3(p3), .p4(p4)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r.itm.valid <= 1'b0;
    end else if (en) begin
      m_r.itm.valid <= p_r.itm.valid;
    end
    if (en) begin
      m_r.itm.op  <= p_r.itm.op;
      m_r.itm.col <= p_r.itm.col;
      m_r.itm.row <= p_r.itm.row;
      m_r.itm.pix <= p_r.itm.pix;
      m_r.inr     <= p_r.inr;
      m_r.a       <= p_r.a;
      m_r.b       <= p_r.b;
    end
  end

  // Stage B1: blend along x
  blend_t          b1_r;
  logic [WGT_W-1:0] wa;
  logic [Q_W-1:0]  q1_nxt, q2_nxt;

  always_comb begin
    wa     = ONE_FX - WGT_W'(m_r.a);
    q1_nxt = Q_W'(wa) * Q_W'(p1) + Q_W'(m_r.a) * Q_W'(p2);
    q2_nxt = Q_W'(wa) * Q_W'(p3) + Q_W'(m_r.a) * Q_W'(p4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_r.itm.valid <= 1'b0;
    end else if (en) begin
      b1_r.itm.valid <= m_r.itm.valid;
    end
    if (en) begin
      b1_r.itm.op  <= m_r.itm.op;
      b1_r.itm.col <= m_r.itm.col;
      b1_r.itm.row <= m_r.itm.row;
      b1_r.itm.pix <= m_r.itm.pix;
      b1_r.inr     <= m_r.inr;
      b1_r.b       <= m_r.b;
      b1_r.q1      <= q1_nxt;
      b1_r.q2      <= q2_nxt;
    end
  end

  // Stage B2: blend along y, truncate, clamp, drop out-of-range samples to zero
  logic [WGT_W-1:0] wb;
  logic [V_W-1:0]   v;
  logic [PIX_W-1:0] pix_nxt;

  always_comb begin
    wb = ONE_FX - WGT_W'(b1_r.b);
    v  = V_W'(wb) * V_W'(b1_r.q1) + V_W'(b1_r.b) * V_W'(b1_r.q2);
    if (!b1_r.inr) begin
      pix_nxt = '0;
    end else if (v[V_W-1:2*FRAC_BITS] > (V_W-2*FRAC_BITS)'(255)) begin
      pix_nxt = '1;
    end else begin
      pix_nxt = v[2*FRAC_BITS+PIX_W-1:2*FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= b1_r.itm.valid && (b1_r.itm.op == OP_SAMPLE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pixel_r <= pix_nxt;
      out_col_r   <= b1_r.itm.col;
      out_row_r   <= b1_r.itm.row;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_row_r, out_col_r, out_pixel_r};

  `BIR_ASSERT_NXT(a_load_silent, en && b1_r.itm.valid && b1_r.itm.op == OP_LOAD, !out_valid_r, "load item produced a result")
  `BIR_ASSERT_NXT(a_oor_zero, en && b1_r.itm.valid && !b1_r.inr, out_pixel_r == '0, "out-of-range sample not zero")
  `BIR_ASSERT_IMP(a_ready_free, !out_valid_r, in_tready, "input stalled with empty output")

endmodule

FILE: verif/bilinear_image_resize_checker.sv
// Scoreboard for the bilinear scaler: watches both streams and the config port.
// Predicts each sample result from its own image store copy; needs bir_pkg.
module bilinear_image_resize_checker
  import bir_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending,
  output int          samples_seen
);

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] col;
    logic [7:0] pix;
  } scaled_px_t;

  logic [7:0]  image_mem [0:65535];
  logic [8:0]  src_w, src_h;
  logic [10:0] dst_w, dst_h;
  scaled_px_t  expected_px[$];

  function automatic int unsigned clamp_size(int unsigned v, int unsigned mx);
    if (v == 0) return 1;
    return (v > mx) ? mx : v;
  endfunction

  function automatic logic [7:0] interpolate(logic [9:0] col, logic [9:0] row);
    longint unsigned sw, sh, dw, dh, px, py, x1, y1, x2, y2, a, b, q1, q2, v;
    sw = clamp_size(src_w, MAX_SRC_WIDTH);
    sh = clamp_size(src_h, MAX_SRC_HEIGHT);
    dw = clamp_size(dst_w, MAX_DST_SIZE);
    dh = clamp_size(dst_h, MAX_DST_SIZE);
    px = ((col * sw) << FRAC_BITS) / dw;
    py = ((row * sh) << FRAC_BITS) / dh;
    if (px >= (sw << FRAC_BITS) || py >= (sh << FRAC_BITS)) return 8'd0;
    x1 = px >> FRAC_BITS;
    y1 = py >> FRAC_BITS;
    a = px & 255;
    b = py & 255;
    x2 = (x1 + 1 >= sw) ? sw - 1 : x1 + 1;
    y2 = (y1 + 1 >= sh) ? sh - 1 : y1 + 1;
    q1 = (256 - a) * image_mem[y1 * 256 + x1] + a * image_mem[y1 * 256 + x2];
    q2 = (256 - a) * image_mem[y2 * 256 + x1] + a * image_mem[y2 * 256 + x2];
    v = ((256 - b) * q1 + b * q2) >> (2 * FRAC_BITS);
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  assign pending = expected_px.size();

  always @(posedge clk) begin
    scaled_px_t got, want;
    if (!rst_n) begin
      src_w <= 9'd256;
      src_h <= 9'd256;
      dst_w <= 11'd512;
      dst_h <= 11'd512;
      fail_count <= 0;
      samples_seen <= 0;
      expected_px.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_SRC_WIDTH:  src_w <= cfg_pwdata[8:0];
          REG_SRC_HEIGHT: src_h <= cfg_pwdata[8:0];
          REG_DST_WIDTH:  dst_w <= cfg_pwdata[10:0];
          REG_DST_HEIGHT: dst_h <= cfg_pwdata[10:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (op_t'(in_tuser) == OP_LOAD) begin
          if (in_tdata[9:0] < MAX_SRC_WIDTH && in_tdata[19:10] < MAX_SRC_HEIGHT)
            image_mem[in_tdata[17:10] * 256 + in_tdata[7:0]] = in_tdata[27:20];
        end else begin
          expected_px.push_back('{row: in_tdata[19:10], col: in_tdata[9:0],
                                  pix: interpolate(in_tdata[9:0], in_tdata[19:10])});
        end
      end
      if (out_tvalid && out_tready) begin
        got = '{row: out_tdata[27:18], col: out_tdata[17:8], pix: out_tdata[7:0]};
        samples_seen <= samples_seen + 1;
        if (expected_px.size() == 0) begin
          $error("result with nothing expected: col %0d row %0d", got.col, got.row);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_px.pop_front();
          if (got.pix !== want.pix)
            $error("pixel_out expected %0d got %0d", want.pix, got.pix);
          if (got.col !== want.col)
            $error("out_col expected %0d got %0d", want.col, got.col);
          if (got.row !== want.row)
            $error("out_row expected %0d got %0d", want.row, got.row);
          if (got !== want) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

FILE: verif/testbench.sv
// Stimulus and verdict for bilinear_image_resize_top.
// Depends on bir_pkg, the RTL top and bilinear_image_resize_checker.
module testbench;
  import bir_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0, in_tready, in_tuser = 1'b0;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid, out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0, cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending, samples_seen;
  int          send_idle_pct, recv_stall_pct;
  int          cycle_count = 0;
  bit          loaded [0:255][0:255];
  logic [8:0]  cur_sw, cur_sh;
  logic [10:0] cur_dw, cur_dh;

  bilinear_image_resize_top uut (.*);

  bilinear_image_resize_checker scoreboard (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("bilinear_image_resize_top: mismatch");
      $finish;
    end
  end

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // valid stays high after the accepting edge; the next idle or drain drops it
  task automatic push_item(op_t op, int c, int r, int p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'd0, 8'(p), 10'(r), 10'(c)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_px(int c, int r, int p);
    push_item(OP_LOAD, c, r, p);
    if (c < 256 && r < 256) loaded[r][c] = 1'b1;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, int v);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1;
    cfg_paddr <= 4'(idx) << 2; cfg_pwdata <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic set_sizes(int sw, int sh, int dw, int dh);
    wait_drained();
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    cur_sw = 9'(sw); cur_sh = 9'(sh); cur_dw = 11'(dw); cur_dh = 11'(dh);
  endtask

  // fill the effective source area so every sample reads written pixels
  task automatic fill_source(int w, int h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        if (!loaded[r][c]) load_px(c, r, $urandom_range(255));
  endtask

  function automatic int eff(int v, int mx);
    return (v == 0) ? 1 : (v > mx ? mx : v);
  endfunction

  task automatic random_phase(int n, int stall, int idle);
    int sw, sh;
    recv_stall_pct = stall; send_idle_pct = idle;
    sw = eff(cur_sw, 256); sh = eff(cur_sh, 256);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        load_px($urandom_range(sw - 1), $urandom_range(sh - 1), $urandom_range(255));
      else if ($urandom_range(9) == 0)
        push_item(OP_SAMPLE, $urandom_range(1023), $urandom_range(1023), $urandom);
      else
        push_item(OP_SAMPLE, $urandom_range(eff(cur_dw, 1024) - 1),
                  $urandom_range(eff(cur_dh, 1024) - 1), $urandom_range(255));
    end
  endtask

  initial begin
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // tiny sources first; loads outside the store are dropped
    set_sizes(4, 3, 9, 7);
    fill_source(4, 3);
    load_px(0, 0, 255); load_px(3, 2, 0); load_px(1, 1, 170);
    load_px(1023, 1023, 255); load_px(256, 5, 1); load_px(5, 256, 1);
    push_item(OP_SAMPLE, 0, 0, 0);
    push_item(OP_SAMPLE, 8, 6, 255);
    push_item(OP_SAMPLE, 9, 0, 0);
    push_item(OP_SAMPLE, 0, 7, 0);
    push_item(OP_SAMPLE, 1023, 1023, 255);
    push_item(OP_SAMPLE, 5, 3, 0);
    random_phase(90, 0, 0);
    // out-of-range register values: zero acts as one, oversize saturates
    set_sizes(0, 0, 0, 0);
    fill_source(1, 1);
    push_item(OP_SAMPLE, 0, 0, 0);
    push_item(OP_SAMPLE, 1, 0, 0);
    random_phase(40, 72, 0);
    set_sizes(511, 1, 2047, 1);
    fill_source(256, 1);
    random_phase(50, 0, 72);
    set_sizes(7, 6, 1, 1024);
    fill_source(7, 6);
    random_phase(60, 30, 30);
    // pause until drained, then random stretch with upscale
    wait_drained();
    set_sizes(12, 8, 100, 37);
    fill_source(12, 8);
    random_phase(40, 0, 0);
    set_sizes(3, 2, 1024, 1024);
    random_phase(40, 72, 72);
    wait_drained();
    $display("Ran directed edge cases, size-register extremes and random loads and samples");
    $display("under mixed stalls; %0d results checked.", samples_seen);
    if (fail_count == 0)
      $display("bilinear_image_resize_top: match");
    else
      $display("bilinear_image_resize_top: mismatch");
    $finish;
  end

endmodule

FILE: bilinear_image_resize_top.f
+incdir+hdl
hdl/bir_pkg.sv
hdl/bir_div.sv
hdl/bir_store.sv
hdl/bilinear_image_resize_top.sv
verif/bilinear_image_resize_checker.sv
verif/testbench.sv
